// ===== rtl/core/ack_retransmit_table_core_defines.svh =====
// Assertion macros used by the retransmission table top level
`ifndef ACK_RETRANSMIT_TABLE_CORE_DEFINES_SVH
`define ACK_RETRANSMIT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define ART_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/art_pkg.sv =====
// Types and constants for the retransmission table
`timescale 1ns / 1ps
`default_nettype none
package art_pkg;

   localparam logic [1:0] MODE_SEND = 2'd0;
   localparam logic [1:0] MODE_ACK  = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam logic [2:0] KIND_SENT      = 3'd0;
   localparam logic [2:0] KIND_SEND_FAIL = 3'd1;
   localparam logic [2:0] KIND_ACK_MATCH = 3'd2;
   localparam logic [2:0] KIND_ACK_MISS  = 3'd3;
   localparam logic [2:0] KIND_RETRY     = 3'd4;
   localparam logic [2:0] KIND_GIVE_UP   = 3'd5;
   localparam logic [2:0] KIND_HEARTBEAT = 3'd6;

   localparam logic [1:0] CSR_RETRY_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_MAX_RETRIES    = 2'd1;
   localparam logic [1:0] CSR_HEARTBEAT      = 2'd2;

   localparam logic [19:0] RETRY_INTERVAL_RESET = 20'd1000;
   localparam logic [3:0]  MAX_RETRIES_RESET    = 4'd3;
   localparam logic [31:0] HEARTBEAT_RESET      = 32'd20000;
   localparam logic [31:0] NEXT_SEQUENCE_RESET  = 32'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND,
      ST_EVICT_SCAN,
      ST_EVICT_WRITE,
      ST_ACK_SCAN,
      ST_TICK_HB,
      ST_TICK_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_en;
      logic send_eval;
      logic evict_write;
      logic ack_eval;
      logic tick_hb;
      logic tick_eval;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic send_track;
      logic free_found;
      logic scan_done;
      logic ack_hit;
   } status_type;

   typedef struct packed {
      logic [31:0] sequence_num;
      logic [3:0]  attempts;
      logic [31:0] due_time;
      logic [47:0] peer;
      logic [3:0]  msg_type;
   } slot_rec_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] sequence_res;
      logic [2:0]  slot;
      logic [3:0]  attempt;
      logic [47:0] dest_address;
      logic [3:0]  report_type;
      logic        tracked;
      logic        evicted;
   } res_type;

endpackage
`default_nettype wire

// ===== rtl/core/art_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module art_ram #(
   parameter int WIDTH = 120,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/art_ctrl.sv =====
// Sequencing state machine for the retransmission table
`timescale 1ns / 1ps
`default_nettype none
module art_ctrl import art_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_mode,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_SEND: state_in = ST_SEND;
                  MODE_ACK:  state_in = ST_ACK_SCAN;
                  MODE_TICK: state_in = ST_TICK_HB;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEND: begin
            if (status.send_track && !status.free_found) begin
               state_in = ST_EVICT_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EVICT_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_EVICT_WRITE;
            end
         end
         ST_EVICT_WRITE: state_in = ST_DONE;
         ST_ACK_SCAN: begin
            if (status.ack_hit || status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_TICK_HB: state_in = ST_TICK_SCAN;
         ST_TICK_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:        cmd.capture = start;
         ST_SEND:        cmd.send_eval = 1'b1;
         ST_EVICT_SCAN:  cmd.scan_en = 1'b1;
         ST_EVICT_WRITE: cmd.evict_write = 1'b1;
         ST_ACK_SCAN: begin
            cmd.scan_en  = 1'b1;
            cmd.ack_eval = 1'b1;
         end
         ST_TICK_HB:     cmd.tick_hb = 1'b1;
         ST_TICK_SCAN: begin
            cmd.scan_en   = 1'b1;
            cmd.tick_eval = 1'b1;
         end
         ST_DONE:        cmd.flush = 1'b1;
         default:        cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/art_dpath.sv =====
// Slot table, scan pipeline, registers and result staging
`timescale 1ns / 1ps
`default_nettype none
module art_dpath import art_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now_ms,
   input  logic        req_send_ok,
   input  logic        req_wants_ack,
   input  logic [3:0]  req_message_type,
   input  logic [47:0] req_peer_address,
   input  logic [31:0] req_acked_sequence,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_sequence_res,
   output logic [2:0]  rsp_slot,
   output logic [3:0]  rsp_attempt,
   output logic [47:0] rsp_dest_address,
   output logic [3:0]  rsp_report_type,
   output logic        rsp_tracked,
   output logic        rsp_evicted,
   output logic        rsp_last
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int RW = $bits(slot_rec_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   // configuration
   logic [19:0] retry_ff;
   logic [3:0]  maxr_ff;
   logic [31:0] hb_int_ff;

   // captured transaction
   logic        mode_send;
   logic [31:0] now_ff;
   logic        ok_ff;
   logic        want_ff;
   logic [3:0]  mtype_ff;
   logic [47:0] peer_ff;
   logic [31:0] ack_seq_ff;
   logic [31:0] seq_ff;

   logic [31:0] next_seq_ff, next_seq_in;
   logic [31:0] last_hb_ff, last_hb_in;
   logic [SLOTS-1:0] active_ff, active_in;

   // scan pipeline
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          ev_vld_ff, ev_vld_in;
   logic [IW-1:0] ev_idx_ff;
   logic          issue;

   logic [31:0]   best_due_ff;
   logic [IW-1:0] best_idx_ff;

   logic          free_found;
   logic [IW-1:0] free_idx;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   slot_rec_type  wr_rec;
   slot_rec_type  rd_rec;
   logic [RW-1:0] rd_raw;

   logic          ev_active;
   logic          ack_hit;
   logic          hb_due;
   logic [3:0]    att_inc;
   logic [23:0]   backoff;
   logic [31:0]   first_due;

   logic          emit;
   res_type       new_res;

   logic          pend_vld_ff, pend_vld_in;
   res_type       pend_ff;
   logic          out_vld_ff, out_vld_in;
   logic          out_last_ff, out_last_in;
   res_type       out_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff  <= RETRY_INTERVAL_RESET;
         maxr_ff   <= MAX_RETRIES_RESET;
         hb_int_ff <= HEARTBEAT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RETRY_INTERVAL: retry_ff  <= csr_wdata[19:0];
            CSR_MAX_RETRIES:    maxr_ff   <= csr_wdata[3:0];
            CSR_HEARTBEAT:      hb_int_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign mode_send = (req_mode == MODE_SEND);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff     <= req_now_ms;
         ok_ff      <= req_send_ok;
         want_ff    <= req_wants_ack;
         mtype_ff   <= req_message_type;
         peer_ff    <= req_peer_address;
         ack_seq_ff <= req_acked_sequence;
         seq_ff     <= next_seq_ff;
      end
   end

   assign next_seq_in = (cmd.capture && mode_send) ? next_seq_ff + 32'd1 : next_seq_ff;

   // scan: issue one read per cycle, evaluate each entry in the cycle after its read
   assign issue     = cmd.scan_en && (rd_cnt_ff < CW'(SLOTS));
   assign ev_vld_in = issue;

   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      if (cmd.capture) begin
         rd_cnt_in = '0;
      end else if (issue) begin
         rd_cnt_in = rd_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         ev_idx_ff <= rd_cnt_ff[IW-1:0];
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   art_ram #(
      .WIDTH (RW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[IW-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_rec    = slot_rec_type'(rd_raw);
   assign ev_active = active_ff[ev_idx_ff];
   assign ack_hit   = ev_vld_ff && ev_active && (rd_rec.sequence_num == ack_seq_ff);
   assign hb_due    = ((now_ff - last_hb_ff) >= hb_int_ff);
   assign att_inc   = rd_rec.attempts + 4'd1;
   assign backoff   = {4'b0, retry_ff} * {20'b0, att_inc};
   assign first_due = now_ff + {12'b0, retry_ff};

   // earliest due time, tie to the lowest index
   always_ff @(posedge clock) begin
      if (ev_vld_ff && ((ev_idx_ff == '0) || (rd_rec.due_time < best_due_ff))) begin
         best_due_ff <= rd_rec.due_time;
         best_idx_ff <= ev_idx_ff;
      end
   end

   assign status.send_track = ok_ff && want_ff;
   assign status.free_found = free_found;
   assign status.scan_done  = ev_vld_ff && (ev_idx_ff == LAST_IDX);
   assign status.ack_hit    = ack_hit;

   always_comb begin
      emit       = 1'b0;
      new_res    = '0;
      wr_en      = 1'b0;
      wr_addr    = free_idx;
      wr_rec.sequence_num = seq_ff;
      wr_rec.attempts     = 4'd1;
      wr_rec.due_time     = first_due;
      wr_rec.peer         = peer_ff;
      wr_rec.msg_type     = mtype_ff;
      active_in  = active_ff;
      last_hb_in = last_hb_ff;

      if (cmd.send_eval) begin
         new_res.sequence_res = seq_ff;
         new_res.report_type  = mtype_ff;
         if (!ok_ff) begin
            emit = 1'b1;
            new_res.kind = KIND_SEND_FAIL;
         end else if (!want_ff) begin
            emit = 1'b1;
            new_res.kind = KIND_SENT;
         end else if (free_found) begin
            emit  = 1'b1;
            wr_en = 1'b1;
            active_in[free_idx] = 1'b1;
            new_res.kind    = KIND_SENT;
            new_res.slot    = 3'(free_idx);
            new_res.attempt = 4'd1;
            new_res.tracked = 1'b1;
         end
      end

      if (cmd.evict_write) begin
         emit    = 1'b1;
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         active_in[best_idx_ff] = 1'b1;
         new_res.kind         = KIND_SENT;
         new_res.sequence_res = seq_ff;
         new_res.slot         = 3'(best_idx_ff);
         new_res.attempt      = 4'd1;
         new_res.report_type  = mtype_ff;
         new_res.tracked      = 1'b1;
         new_res.evicted      = 1'b1;
      end

      if (cmd.ack_eval) begin
         new_res.sequence_res = ack_seq_ff;
         if (ack_hit) begin
            emit = 1'b1;
            active_in[ev_idx_ff] = 1'b0;
            new_res.kind        = KIND_ACK_MATCH;
            new_res.slot        = 3'(ev_idx_ff);
            new_res.attempt     = rd_rec.attempts;
            new_res.report_type = rd_rec.msg_type;
         end else if (status.scan_done) begin
            emit = 1'b1;
            new_res.kind = KIND_ACK_MISS;
         end
      end

      if (cmd.tick_hb && hb_due) begin
         emit         = 1'b1;
         last_hb_in   = now_ff;
         new_res.kind = KIND_HEARTBEAT;
      end

      if (cmd.tick_eval && ev_vld_ff && ev_active && (now_ff >= rd_rec.due_time)) begin
         emit = 1'b1;
         new_res.sequence_res = rd_rec.sequence_num;
         new_res.slot         = 3'(ev_idx_ff);
         new_res.report_type  = rd_rec.msg_type;
         if (rd_rec.attempts >= maxr_ff) begin
            active_in[ev_idx_ff] = 1'b0;
            new_res.kind    = KIND_GIVE_UP;
            new_res.attempt = rd_rec.attempts;
         end else begin
            wr_en   = 1'b1;
            wr_addr = ev_idx_ff;
            wr_rec.sequence_num = rd_rec.sequence_num;
            wr_rec.attempts     = att_inc;
            wr_rec.due_time     = now_ff + {8'b0, backoff};
            wr_rec.peer         = rd_rec.peer;
            wr_rec.msg_type     = rd_rec.msg_type;
            new_res.kind         = KIND_RETRY;
            new_res.attempt      = att_inc;
            new_res.dest_address = rd_rec.peer;
         end
      end
   end

   // hold one result back so the final one of a transaction can carry last
   always_comb begin
      pend_vld_in = pend_vld_ff;
      out_vld_in  = 1'b0;
      out_last_in = 1'b0;
      if (emit) begin
         pend_vld_in = 1'b1;
         out_vld_in  = pend_vld_ff;
      end else if (cmd.flush && pend_vld_ff) begin
         pend_vld_in = 1'b0;
         out_vld_in  = 1'b1;
         out_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pend_ff <= new_res;
      end
      if (out_vld_in) begin
         out_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff <= NEXT_SEQUENCE_RESET;
         last_hb_ff  <= '0;
         active_ff   <= '0;
         rd_cnt_ff   <= '0;
         ev_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         next_seq_ff <= next_seq_in;
         last_hb_ff  <= last_hb_in;
         active_ff   <= active_in;
         rd_cnt_ff   <= rd_cnt_in;
         ev_vld_ff   <= ev_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_sequence_res = out_ff.sequence_res;
   assign rsp_slot         = out_ff.slot;
   assign rsp_attempt      = out_ff.attempt;
   assign rsp_dest_address = out_ff.dest_address;
   assign rsp_report_type  = out_ff.report_type;
   assign rsp_tracked      = out_ff.tracked;
   assign rsp_evicted      = out_ff.evicted;

endmodule
`default_nettype wire

// ===== rtl/core/ack_retransmit_table_core.sv =====
// Top level of the retransmission table for unacknowledged sends
//
//   channel  | ports            | handshake
//   ---------+------------------+------------------------------------------
//   request  | start/busy, req_ | taken when start is high and busy is low
//   response | rsp_valid, rsp_  | one-cycle strobe, rsp_last on the final one
//   config   | csr_valid/ready  | taken when csr_valid and csr_ready are high
//
// A send passes SEND and DONE; on a full table it first scans for the slot with the
// earliest due time and overwrites it. An ack scans up to a match or the last slot,
// a tick checks the heartbeat, then scans: the slot RAM is read one entry per cycle,
// each evaluated in the cycle after. A result waits until the next is found or DONE
// flushes it, then leaves. Reset clears the active flags, sets the sequence counter
// and CSRs to their defaults. Results cannot be stalled; busy falls as the last shows.
`timescale 1ns / 1ps
`default_nettype none
`include "ack_retransmit_table_core_defines.svh"
module ack_retransmit_table_core import art_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now_ms,
   input  logic        req_send_ok,
   input  logic        req_wants_ack,
   input  logic [3:0]  req_message_type,
   input  logic [47:0] req_peer_address,
   input  logic [31:0] req_acked_sequence,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_sequence_res,
   output logic [2:0]  rsp_slot,
   output logic [3:0]  rsp_attempt,
   output logic [47:0] rsp_dest_address,
   output logic [3:0]  rsp_report_type,
   output logic        rsp_tracked,
   output logic        rsp_evicted,
   output logic        rsp_last
);

   cmd_type    cmd;
   status_type status;
   logic       req_take;
   logic       rsp_final;

   art_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   art_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_now_ms         (req_now_ms),
      .req_send_ok        (req_send_ok),
      .req_wants_ack      (req_wants_ack),
      .req_message_type   (req_message_type),
      .req_peer_address   (req_peer_address),
      .req_acked_sequence (req_acked_sequence),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_slot           (rsp_slot),
      .rsp_attempt        (rsp_attempt),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_report_type    (rsp_report_type),
      .rsp_tracked        (rsp_tracked),
      .rsp_evicted        (rsp_evicted),
      .rsp_last           (rsp_last)
   );

   assign req_take  = start && !busy
                      && (req_mode == MODE_SEND || req_mode == MODE_ACK || req_mode == MODE_TICK);
   assign rsp_final = rsp_valid && rsp_last;

   `ART_ASSERT_NEXT(a_start_goes_busy, req_take, busy, "accepted transaction did not raise busy")
   `ART_ASSERT_SAME(a_rsp_from_work, rsp_valid, $past(busy), "result issued while idle")
   `ART_ASSERT_NEXT(a_last_ends_burst, rsp_final, !rsp_valid, "result after the final one")
   `ART_ASSERT_SAME(a_scan_only_busy, cmd.scan_en, busy, "slot scan while idle")

endmodule
`default_nettype wire
